[sv/pnc_pkg.sv]
// Shared types for the palette nearest-color mapper: request and response beats,
// controller state, and the command/status groups between controller and datapath.
// No dependencies.
package pnc_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned DIST_W = 18;
	localparam int unsigned SIZE_W = 9;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_PIXEL = 1'b1
	} pnc_mode_t;

	typedef struct packed {
		pnc_mode_t   mode;
		logic [7:0]  entry_index;
		logic [31:0] color;
		logic        last_pixel;
	} pnc_in_t;

	typedef struct packed {
		logic [7:0]        palette_index;
		logic [DIST_W-1:0] distance;
		logic              found;
		logic              frame_end;
	} pnc_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} pnc_state_t;

	typedef struct packed {
		logic wr;    // store one palette word
		logic load;  // capture a pixel and clear the search
		logic issue; // read the next palette entry
		logic emit;  // register the result beat
	} pnc_cmd_t;

	typedef struct packed {
		logic empty;     // palette in use has no entries
		logic last_addr; // the entry being read now is the last one
		logic hit;       // an exact match has been found
		logic pipe_busy; // entries still in flight
	} pnc_sts_t;

endpackage

[sv/pnc_ctrl.sv]
// Controller of the palette nearest-color mapper: sequences the palette scan.
// Depends on pnc_pkg.
module pnc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pnc_pkg::pnc_mode_t mode,
	input  pnc_pkg::pnc_sts_t  sts,
	output pnc_pkg::pnc_cmd_t  cmd,
	output logic              busy
);
	import pnc_pkg::*;

	pnc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (mode == MODE_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = sts.empty ? ST_RESULT : ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// Stop reading once an exact match is known; later reads are discarded.
				if (sts.hit) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.issue = 1'b1;
					if (sts.last_addr) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[sv/pnc_dpath.sv]
// Datapath of the palette nearest-color mapper: palette memory, distance unit,
// best-match tracking and the result register. Depends on pnc_pkg.
module pnc_dpath #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pnc_pkg::pnc_in_t            req,
	input  logic                        cfg_we,
	input  logic [pnc_pkg::SIZE_W-1:0]  cfg_wdata,
	input  pnc_pkg::pnc_cmd_t           cmd,
	output pnc_pkg::pnc_sts_t           sts,
	output pnc_pkg::pnc_out_t           rsp,
	output logic                        done
);
	import pnc_pkg::*;

	localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
	localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam logic [DIST_W-1:0] DIST_START = '1;

	function automatic logic [2*CHAN_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
	endfunction

	logic [31:0]       mem [PALETTE_DEPTH];
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n_sat;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  addr_q;
	logic [31:0]       pix_q;
	logic              last_q;

	logic [31:0]       rd_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              v_s1;
	logic [2*CHAN_W-1:0] sq_s2 [4];
	logic [IDX_W-1:0]  idx_s2;
	logic              v_s2;
	logic [DIST_W-1:0] dist_s2;

	logic [DIST_W-1:0] best_d_q;
	logic [IDX_W-1:0]  best_i_q;
	logic              hit_q;
	pnc_out_t          rsp_q;
	logic              done_q;
	logic              wr_ok;

	// A size beyond the store saturates to the store depth.
	assign n_sat = (size_q > SIZE_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH)
		: size_q[CNT_W-1:0];
	assign wr_ok = cmd.wr && ({1'b0, req.entry_index} < 9'(PALETTE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[req.entry_index[IDX_W-1:0]] <= req.color;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			hit_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.issue) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			done_q <= cmd.emit;
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (v_s2 && !hit_q && dist_s2 == '0) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign dist_s2 = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1])
		+ DIST_W'(sq_s2[2]) + DIST_W'(sq_s2[3]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q  <= req.color;
			last_q <= req.last_pixel;
			n_q    <= n_sat;
		end
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		for (int c = 0; c < 4; c++) begin
			sq_s2[c] <= chan_sq(rd_s1[c*CHAN_W +: CHAN_W], pix_q[c*CHAN_W +: CHAN_W]);
		end
		// First strict minimum wins; nothing changes after an exact match.
		if (cmd.load) begin
			best_d_q <= DIST_START;
			best_i_q <= '0;
		end else if (v_s2 && !hit_q && dist_s2 < best_d_q) begin
			best_d_q <= dist_s2;
			best_i_q <= idx_s2;
		end
		if (cmd.emit) begin
			rsp_q.found         <= (n_q != '0);
			rsp_q.palette_index <= (n_q != '0) ? 8'(best_i_q) : 8'd0;
			rsp_q.distance      <= (n_q != '0) ? best_d_q : '0;
			rsp_q.frame_end     <= last_q;
		end
	end

	assign sts.empty     = (n_sat == '0);
	assign sts.last_addr = (CNT_W'(addr_q) == n_q - CNT_W'(1));
	assign sts.hit       = hit_q;
	assign sts.pipe_busy = v_s1 || v_s2;

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

[sv/palette_nearest_color_mapper.sv]
// Top level of the palette nearest-color mapper: joins controller and datapath.
// Depends on pnc_pkg, pnc_ctrl and pnc_dpath.
//
// Usage: a request beat on req is taken at a rising edge where start is high
// and busy is low. A write beat (mode 0) stores req.color in palette slot
// req.entry_index in that cycle; slots at or above PALETTE_DEPTH are ignored.
// Write beats never raise busy and give no response.
// A pixel beat (mode 1) raises busy and scans entries 0 to N-1, where N is
// palette_size saturated to PALETTE_DEPTH, one entry per cycle through a
// single distance unit fed by the palette memory's read port. An exact match
// ends the scan early, and an empty palette is not scanned. The response beat
// appears on rsp for one cycle, marked by done. busy falls in the cycle done
// rises, so the next beat may be taken while the response is shown.
// palette_size is written through cfg_we/cfg_wdata while the block is idle.
// Reset clears palette_size and the controller; palette contents are not
// cleared and must be written before they are searched.
// The receiver cannot stall: every response beat is taken as it appears.
module palette_nearest_color_mapper #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pnc_pkg::pnc_in_t           req,
	output logic                       done,
	output pnc_pkg::pnc_out_t          rsp,
	input  logic                       cfg_we,
	input  logic [pnc_pkg::SIZE_W-1:0] cfg_wdata
);
	import pnc_pkg::*;

	pnc_cmd_t cmd;
	pnc_sts_t sts;

	pnc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (req.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	pnc_dpath #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.done      (done)
	);

endmodule

[sv/pnc_checker.sv]
// Port-level checks for the palette nearest-color mapper, bound to the top level.
// Depends on pnc_pkg.
module pnc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input pnc_pkg::pnc_in_t           req,
	input logic                       done,
	input pnc_pkg::pnc_out_t          rsp
);
	import pnc_pkg::*;

	// A response beat only follows a cycle in which a pixel was being worked on.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response beat without preceding pixel work");

	// One pixel gives one response beat.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("response beat repeated");

	// A taken pixel beat always raises busy, also for an empty palette.
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.mode == MODE_PIXEL) |=> busy)
		else $error("pixel beat taken without starting a search");

	// An empty palette reports index 0 at distance 0.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.found) |-> (rsp.distance == '0 && rsp.palette_index == '0))
		else $error("empty palette response not zero");

endmodule

bind palette_nearest_color_mapper pnc_checker u_pnc_checker (.*);

[bench/palette_nearest_color_mapper_tb.sv]
// Testbench for palette_nearest_color_mapper: drives write and pixel beats, predicts each
// nearest-entry response from a shadow palette, and checks every response beat.
// Depends on pnc_pkg and the palette_nearest_color_mapper RTL.
`timescale 1ns / 1ps

module palette_nearest_color_mapper_tb;
	import pnc_pkg::*;

	localparam int unsigned DEPTH = 256;
	localparam int unsigned IN_W = $bits(pnc_in_t);
	localparam logic [31:0] DIST_INIT = 32'h7FFF_FFFF;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	pnc_in_t           req;
	logic              done;
	pnc_out_t          rsp;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	logic [31:0]       shadow_palette [DEPTH];
	logic [SIZE_W-1:0] size_setting;
	pnc_out_t          expected_matches [$];
	int unsigned       mismatch_count;
	bit                gaps_on;

	palette_nearest_color_mapper #(
		.PALETTE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned color_distance(input logic [31:0] a, input logic [31:0] b);
		int diff;
		int unsigned sum;
		sum = 0;
		for (int ch = 0; ch < 4; ch++) begin
			diff = int'(a[8*ch +: 8]) - int'(b[8*ch +: 8]);
			sum += diff * diff;
		end
		return sum;
	endfunction

	// Linear scan with first strict minimum; an exact match stops the scan.
	function automatic pnc_out_t predict_nearest(input logic [31:0] pixel, input logic last);
		pnc_out_t    r;
		int unsigned n;
		int unsigned d;
		int unsigned best_d;
		int unsigned best_i;
		int unsigned i;
		bit          hit;
		n = (size_setting > DEPTH) ? DEPTH : size_setting;
		best_d = DIST_INIT;
		best_i = 0;
		hit = 1'b0;
		for (i = 0; i < n && !hit; i++) begin
			d = color_distance(shadow_palette[i], pixel);
			if (d == 0) begin
				best_d = 0;
				best_i = i;
				hit = 1'b1;
			end else if (d < best_d) begin
				best_d = d;
				best_i = i;
			end
		end
		r = '0;
		if (n != 0) begin
			r.palette_index = best_i[7:0];
			r.distance = best_d[DIST_W-1:0];
			r.found = 1'b1;
		end
		r.frame_end = last;
		return r;
	endfunction

	function automatic int unsigned used_entries();
		return (size_setting > DEPTH) ? DEPTH : size_setting;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// start is left high so back-to-back beats need no gap.
	task automatic send_beat(input pnc_mode_t mode, input logic [7:0] index,
			input logic [31:0] color, input logic last);
		pnc_in_t item;
		item.mode = mode;
		item.entry_index = index;
		item.color = color;
		item.last_pixel = last;
		while (gaps_on && $urandom_range(0, 99) < 26) begin
			start <= 1'b0;
			req <= pnc_in_t'(IN_W'({$urandom, $urandom}));
			@(negedge clk);
		end
		start <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (busy);
		if (mode == MODE_WRITE)
			shadow_palette[index] = color;
		else
			expected_matches.push_back(predict_nearest(color, last));
		@(negedge clk);
	endtask

	task automatic wait_all_responses();
		start <= 1'b0;
		@(negedge clk);
		while (expected_matches.size() != 0)
			@(negedge clk);
	endtask

	// Only written with the block idle: all responses in, plus a few settling cycles.
	task automatic set_palette_size(input logic [SIZE_W-1:0] value);
		wait_all_responses();
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		size_setting = value;
		cfg_we <= 1'b0;
		cfg_wdata <= SIZE_W'($urandom);
	endtask

	// Empty palette straight after reset: index and distance zero, found low.
	task automatic test_empty_palette();
		send_beat(MODE_PIXEL, 8'h00, 32'h0000_0000, 1'b0);
		send_beat(MODE_PIXEL, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		send_beat(MODE_WRITE, 8'h07, 32'h1234_5678, 1'b1);
		send_beat(MODE_PIXEL, 8'h07, 32'h1234_5678, 1'b0);
	endtask

	// Every slot gets written so that no search ever reads an unwritten word.
	task automatic test_fill_palette();
		send_beat(MODE_WRITE, 8'd0, 32'h0000_0000, 1'b0);
		for (int i = 1; i < DEPTH - 1; i++)
			send_beat(MODE_WRITE, 8'(i), $urandom, 1'($urandom));
		send_beat(MODE_WRITE, 8'd255, 32'hFFFF_FFFF, 1'b1);
	endtask

	task automatic test_nearest_cases();
		// One black entry against a white pixel gives the largest distance.
		set_palette_size(9'd1);
		send_beat(MODE_PIXEL, 8'h00, 32'hFFFF_FFFF, 1'b1);
		send_beat(MODE_PIXEL, 8'h5A, 32'h0000_0000, 1'b0);
		// Two equal entries: the first one wins the tie and the exact match.
		set_palette_size(9'd3);
		send_beat(MODE_WRITE, 8'd1, 32'h8080_8080, 1'b0);
		send_beat(MODE_WRITE, 8'd2, 32'h8080_8080, 1'b1);
		send_beat(MODE_PIXEL, 8'h00, 32'h8080_8081, 1'b0);
		send_beat(MODE_PIXEL, 8'h00, 32'h8080_8080, 1'b1);
		send_beat(MODE_PIXEL, 8'h00, 32'h7F80_8181, 1'b0);
		set_palette_size(9'd256);
		send_beat(MODE_PIXEL, 8'h00, shadow_palette[255], 1'b0);
		send_beat(MODE_PIXEL, 8'h00, shadow_palette[128], 1'b1);
		send_beat(MODE_PIXEL, 8'h00, $urandom, 1'b0);
	endtask

	// Sizes above the store depth search the whole store; a size of zero gives an empty palette.
	task automatic test_size_saturation();
		set_palette_size(9'd300);
		send_beat(MODE_PIXEL, 8'h00, $urandom, 1'b1);
		set_palette_size(9'd511);
		send_beat(MODE_PIXEL, 8'h00, $urandom, 1'b0);
		set_palette_size(9'd0);
		send_beat(MODE_PIXEL, 8'h00, $urandom, 1'b1);
	endtask

	task automatic random_phase(input logic [SIZE_W-1:0] size, input int count,
			input bit idle_free);
		int unsigned n;
		int unsigned pick;
		logic [7:0]  slot;
		logic [31:0] pixel;
		set_palette_size(size);
		gaps_on = !idle_free;
		n = used_entries();
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 9);
			slot = (n == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1));
			if (pick < 3) begin
				// Rewrite an entry, mostly inside the range in use.
				if ($urandom_range(0, 3) == 0)
					slot = 8'($urandom);
				send_beat(MODE_WRITE, slot, $urandom, 1'($urandom));
			end else begin
				case (pick)
					3, 4: pixel = $urandom;
					5, 6, 7: pixel = shadow_palette[slot] ^ ($urandom & 32'h0303_0303);
					8: pixel = shadow_palette[slot];
					default: pixel = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
				endcase
				send_beat(MODE_PIXEL, 8'($urandom), pixel, 1'($urandom));
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		random_phase(9'd1, 170, 1'b0);
		random_phase(9'd2, 170, 1'b0);
		random_phase(9'd5, 170, 1'b0);
		random_phase(9'd16, 200, 1'b1);
		random_phase(9'd37, 170, 1'b0);
		random_phase(9'd0, 120, 1'b0);
		random_phase(9'd64, 170, 1'b0);
		random_phase(9'd256, 40, 1'b0);
		random_phase(9'd100, 150, 1'b0);
		random_phase(9'd511, 40, 1'b0);
		random_phase(9'd8, 170, 1'b0);
		random_phase(9'd200, 60, 1'b0);
	endtask

	// Every response beat is taken as it appears; compare with the oldest prediction.
	always @(posedge clk) begin
		pnc_out_t want;
		if (arst_n && done) begin
			if (expected_matches.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: response beat with none pending: index %0d dist %0d",
						$realtime, rsp.palette_index, rsp.distance);
			end else begin
				want = expected_matches.pop_front();
				if (rsp.palette_index !== want.palette_index || rsp.distance !== want.distance
						|| rsp.found !== want.found || rsp.frame_end !== want.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: expected idx %0d dist %0d found %0b end %0b,",
							$realtime, want.palette_index, want.distance, want.found,
							want.frame_end, " got idx %0d dist %0d found %0b end %0b",
							rsp.palette_index, rsp.distance, rsp.found, rsp.frame_end);
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		size_setting = '0;
		mismatch_count = 0;
		gaps_on = 1'b1;
		foreach (shadow_palette[i])
			shadow_palette[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_palette();
		test_fill_palette();
		test_nearest_cases();
		test_size_saturation();
		test_random_traffic();

		wait_all_responses();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && expected_matches.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
